### rtl/mbaf_pkg.sv
`timescale 1ns / 1ps

package mbaf_pkg;

   // Framing characters of the serial stream.
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // Frame error codes carried in the end of frame report.
   localparam logic [1:0] FERR_NONE     = 2'd0;
   localparam logic [1:0] FERR_ODD      = 2'd1;
   localparam logic [1:0] FERR_SHORT    = 2'd2;
   localparam logic [1:0] FERR_OVERFLOW = 2'd3;

   // Result kinds.
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Minimum frame length, LRC included, and the report count limit.
   localparam int unsigned MIN_FRAME_BYTES = 3;
   localparam int unsigned COUNT_LIMIT     = 511;

   // One result item.
   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
      logic       last;
      logic       lrc_ok;
      logic [1:0] frame_error;
      logic [8:0] byte_count;
   } mbaf_result_type;

   // Hex digit value; any character that is not a hex digit gives zero.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 4'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 4'(c - 8'h61 + 8'd10);
      end
      return v;
   endfunction

endpackage

### rtl/modbus_ascii_frame_receiver_top.sv
`timescale 1ns / 1ps

// Modbus ASCII receiver with LRC check.
// The req_ channel carries one received character per transfer. The rsp_
// channel returns decoded frame bytes (tuser low) and one end of frame
// report per CR LF (tuser high, tlast high) with the LRC result, the
// byte count and an error code. The LRC byte itself is never returned
// as a byte.
// An accepted character is held in the input register; its result, if
// any, then goes into the output register, which drives rsp_tvalid. One
// character is taken in every cycle while the output register is empty
// or being drained, so the throughput is one character per cycle.
// Reset empties both registers and leaves the block outside a frame, so
// every character up to the first colon is ignored.
// When rsp_tready is low with a result waiting, the input register holds
// its character and req_tready drops until the result is taken.
module modbus_ascii_frame_receiver_top #(
   parameter int unsigned MAX_FRAME_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] byte_value, [8] lrc_ok,
                                    // [10:9] frame_error, [19:11] byte_count,
                                    // [23:20] zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast    // last
);
   import mbaf_pkg::*;

   logic            in_valid_ff;
   logic [7:0]      in_char_ff;
   logic            out_valid_ff,  out_valid_in;
   mbaf_result_type out_data_ff;
   logic            advance;
   logic            res_valid;
   mbaf_result_type res_data;

   // The held character moves on when the output register can take a result.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
      end
   end

   mbaf_core #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_char   (in_char_ff),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   // Output register.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_data_ff <= res_data;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_data_ff.kind;
   assign rsp_tlast  = out_data_ff.last;
   assign rsp_tdata  = {4'd0, out_data_ff.byte_count, out_data_ff.frame_error,
                        out_data_ff.lrc_ok, out_data_ff.byte_value};

endmodule

### rtl/mbaf_core.sv
`timescale 1ns / 1ps

module mbaf_core #(
   parameter int unsigned MAX_FRAME_BYTES = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               rx_char,
   output logic                     res_valid,
   output mbaf_pkg::mbaf_result_type res_data
);
   import mbaf_pkg::*;

   localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

   // Frame state.
   logic          in_frame_ff,    in_frame_in;
   logic          digit_phase_ff, digit_phase_in;
   logic [3:0]    high_nibble_ff, high_nibble_in;
   logic [7:0]    held_byte_ff,   held_byte_in;
   logic          held_valid_ff,  held_valid_in;
   logic [7:0]    running_sum_ff, running_sum_in;
   logic [CW-1:0] bytes_seen_ff,  bytes_seen_in;
   logic          saw_return_ff,  saw_return_in;
   logic          overflowed_ff,  overflowed_in;

   logic [3:0]    nibble;
   logic [7:0]    new_byte;
   logic [8:0]    report_count;
   logic [1:0]    report_error;

   assign nibble   = hex_value(rx_char);
   assign new_byte = {high_nibble_ff, nibble};

   // Count and error code for the end of frame report.
   always_comb begin
      if (32'(bytes_seen_ff) > COUNT_LIMIT) begin
         report_count = 9'(COUNT_LIMIT);
      end else begin
         report_count = 9'(bytes_seen_ff);
      end
      if (overflowed_ff) begin
         report_error = FERR_OVERFLOW;
      end else if (digit_phase_ff) begin
         report_error = FERR_ODD;
      end else if (32'(bytes_seen_ff) < MIN_FRAME_BYTES) begin
         report_error = FERR_SHORT;
      end else begin
         report_error = FERR_NONE;
      end
   end

   // Per-character state update and result selection.
   always_comb begin
      in_frame_in    = in_frame_ff;
      digit_phase_in = digit_phase_ff;
      high_nibble_in = high_nibble_ff;
      held_byte_in   = held_byte_ff;
      held_valid_in  = held_valid_ff;
      running_sum_in = running_sum_ff;
      bytes_seen_in  = bytes_seen_ff;
      saw_return_in  = saw_return_ff;
      overflowed_in  = overflowed_ff;
      res_valid      = 1'b0;
      res_data       = '0;

      if (step) begin
         if (rx_char == CHAR_COLON) begin
            // A colon always opens a fresh frame, dropping any open one.
            in_frame_in    = 1'b1;
            digit_phase_in = 1'b0;
            high_nibble_in = 4'd0;
            held_byte_in   = 8'd0;
            held_valid_in  = 1'b0;
            running_sum_in = 8'd0;
            bytes_seen_in  = '0;
            saw_return_in  = 1'b0;
            overflowed_in  = 1'b0;
         end else if (in_frame_ff) begin
            saw_return_in = 1'b0;
            if (saw_return_ff && rx_char == CHAR_LF) begin
               // CR LF closes the frame with a report.
               res_valid            = 1'b1;
               res_data.kind        = KIND_END;
               res_data.last        = 1'b1;
               res_data.lrc_ok      = (running_sum_ff == 8'd0);
               res_data.frame_error = report_error;
               res_data.byte_count  = report_count;
               in_frame_in    = 1'b0;
               digit_phase_in = 1'b0;
               held_valid_in  = 1'b0;
               bytes_seen_in  = '0;
               overflowed_in  = 1'b0;
               running_sum_in = 8'd0;
            end else if (rx_char == CHAR_CR) begin
               saw_return_in = 1'b1;
            end else if (!digit_phase_ff) begin
               high_nibble_in = nibble;
               digit_phase_in = 1'b1;
            end else begin
               digit_phase_in = 1'b0;
               if (32'(bytes_seen_ff) >= MAX_FRAME_BYTES) begin
                  overflowed_in = 1'b1;
               end else begin
                  // The previous byte goes out; the new one is held back.
                  if (held_valid_ff) begin
                     res_valid           = 1'b1;
                     res_data.kind       = KIND_BYTE;
                     res_data.byte_value = held_byte_ff;
                  end
                  held_byte_in   = new_byte;
                  held_valid_in  = 1'b1;
                  running_sum_in = running_sum_ff + new_byte;
                  bytes_seen_in  = bytes_seen_ff + CW'(1);
               end
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         digit_phase_ff <= 1'b0;
         held_valid_ff  <= 1'b0;
         bytes_seen_ff  <= '0;
         saw_return_ff  <= 1'b0;
         overflowed_ff  <= 1'b0;
         running_sum_ff <= 8'd0;
      end else begin
         in_frame_ff    <= in_frame_in;
         digit_phase_ff <= digit_phase_in;
         held_valid_ff  <= held_valid_in;
         bytes_seen_ff  <= bytes_seen_in;
         saw_return_ff  <= saw_return_in;
         overflowed_ff  <= overflowed_in;
         running_sum_ff <= running_sum_in;
      end
   end

   // Data held for the frame; always set before use by a colon.
   always_ff @(posedge clock) begin
      high_nibble_ff <= high_nibble_in;
      held_byte_ff   <= held_byte_in;
   end

endmodule
